// ----- rtl/assert_macros.svh -----
// assertion macros shared by the timer bank modules
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked on every rising edge outside reset
`define OTB_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("timer bank check failed");

// property checked on every rising edge, reset included
`define OTB_ASSERT_ALWAYS(lbl, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("timer bank reset check failed");

`endif

// ----- rtl/otb_pkg.sv -----
// shared constants, codes and control types for the one-shot timer bank
package otb_pkg;

  localparam int SLOTS         = 16;
  localparam int DURATION_BITS = 32;
  localparam int FIELD_SLOTS   = 16;
  localparam int USED_SLOTS    = (SLOTS < FIELD_SLOTS) ? SLOTS : FIELD_SLOTS;
  localparam int IDX_W         = (USED_SLOTS > 1) ? $clog2(USED_SLOTS) : 1;

  // word field widths
  localparam int REQ_W   = 2;
  localparam int DUR_W   = 32;
  localparam int TAG_W   = 8;
  localparam int SLOT_W  = 4;
  localparam int STAT_W  = 2;
  localparam int IN_W    = 48;
  localparam int OUT_W   = 16;

  // input word field offsets
  localparam int IN_DUR_LO  = 0;
  localparam int IN_TAG_LO  = IN_DUR_LO + DUR_W;
  localparam int IN_SID_LO  = IN_TAG_LO + TAG_W;

  // request kinds
  localparam logic [REQ_W-1:0] REQ_TICK = 2'd0;
  localparam logic [REQ_W-1:0] REQ_SET  = 2'd1;
  localparam logic [REQ_W-1:0] REQ_KILL = 2'd2;

  // result status codes
  localparam logic [STAT_W-1:0] ST_OK      = 2'd0;
  localparam logic [STAT_W-1:0] ST_ERROR   = 2'd1;
  localparam logic [STAT_W-1:0] ST_FULL    = 2'd2;
  localparam logic [STAT_W-1:0] ST_EXPIRED = 2'd3;

  // controller to datapath commands
  typedef struct packed {
    logic load;    // capture the input word, clear the walk index
    logic single;  // execute set, kill or unknown request, load its result
    logic step;    // process the slot under the walk index
  } otb_cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic req_tick;  // captured request is a tick
    logic hit;       // slot under the walk index expires on this tick
    logic out_free;  // output register can take a result this cycle
    logic idx_last;  // walk index is on the last used slot
  } otb_sts_t;

endpackage

// ----- rtl/otb_ctrl.sv -----
// controller state machine: sequences request capture, execution and the tick walk
`include "assert_macros.svh"

module otb_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  output logic              in_tready,
  input  otb_pkg::otb_sts_t sts,
  output otb_pkg::otb_cmd_t cmd
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_WALK
  } state_t;

  state_t state_r, state_nxt;
  logic   in_tready_r;
  logic   step_ok;

  assign in_tready = in_tready_r;
  // a slot that expires must find room in the output register
  assign step_ok   = !sts.hit || sts.out_free;

  // next state and commands
  always_comb begin
    state_nxt  = state_r;
    cmd.load   = 1'b0;
    cmd.single = 1'b0;
    cmd.step   = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        if (in_tvalid && in_tready_r) begin
          cmd.load  = 1'b1;
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        if (sts.req_tick) begin
          state_nxt = S_WALK;
        end else if (sts.out_free) begin
          cmd.single = 1'b1;
          state_nxt  = S_IDLE;
        end
      end
      S_WALK: begin
        if (step_ok) begin
          cmd.step = 1'b1;
          if (sts.idx_last) begin
            state_nxt = S_IDLE;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // state and registered ready
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      in_tready_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      in_tready_r <= (state_nxt == S_IDLE);
    end
  end

  // the walk ends right after the last slot is stepped
  `OTB_ASSERT(a_walk_ends, (state_r == S_WALK && cmd.step && sts.idx_last) |=> (state_r == S_IDLE))
  // no word is taken while a request is still being worked on
  `OTB_ASSERT(a_ready_only_idle, in_tready_r |-> (state_r == S_IDLE))

endmodule

// ----- rtl/otb_dp.sv -----
// datapath: slot table, tick walk, request decode and output register
`include "assert_macros.svh"

module otb_dp (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic [otb_pkg::IN_W-1:0]            in_tdata,
  input  logic [otb_pkg::REQ_W-1:0]           in_tuser,
  output logic                                out_tvalid,
  input  logic                                out_tready,
  output logic [otb_pkg::OUT_W-1:0]           out_tdata,
  output logic [otb_pkg::STAT_W-1:0]          out_tuser,
  output logic                                out_tlast,
  input  otb_pkg::otb_cmd_t                   cmd,
  output otb_pkg::otb_sts_t                   sts
);

  localparam int NS = otb_pkg::USED_SLOTS;
  localparam int IW = otb_pkg::IDX_W;
  localparam int DW = otb_pkg::DURATION_BITS;

  // captured request
  logic [otb_pkg::REQ_W-1:0]  req_r;
  logic [DW-1:0]              dur_r;
  logic [otb_pkg::TAG_W-1:0]  tag_r;
  logic [otb_pkg::SLOT_W-1:0] sid_r;

  // slot table
  logic [NS-1:0]              run_r;
  logic [DW-1:0]              rem_r [NS];
  logic [otb_pkg::TAG_W-1:0]  stag_r [NS];
  logic [IW-1:0]              idx_r;

  // output register
  logic                       out_valid_r;
  logic [otb_pkg::STAT_W-1:0] out_stat_r;
  logic [otb_pkg::SLOT_W-1:0] out_slot_r;
  logic [otb_pkg::TAG_W-1:0]  out_tag_r;
  logic                       out_last_r;

  logic [NS-1:0]              exp_vec;
  logic                       later_exp;
  logic                       hit;
  logic                       out_free;
  logic                       free_any;
  logic [IW-1:0]              free_idx;
  logic                       kill_ok;
  logic                       set_bad;
  logic [IW-1:0]              sid_idx;

  // result of a single request
  logic [otb_pkg::STAT_W-1:0] res_stat;
  logic [otb_pkg::SLOT_W-1:0] res_slot;
  logic                       do_set;
  logic                       do_kill;
  logic                       load_out;

  // slots that would reach zero on this tick
  always_comb begin
    for (int i = 0; i < NS; i++) begin
      exp_vec[i] = run_r[i] && (rem_r[i] == DW'(1));
    end
  end

  // any expiry above the walk index decides the last mark
  always_comb begin
    later_exp = 1'b0;
    for (int i = 0; i < NS; i++) begin
      if (IW'(i) > idx_r) begin
        later_exp = later_exp | exp_vec[i];
      end
    end
  end

  assign hit      = exp_vec[idx_r];
  assign out_free = !out_valid_r || out_tready;

  // lowest free slot
  always_comb begin
    free_any = 1'b0;
    free_idx = '0;
    for (int i = NS - 1; i >= 0; i--) begin
      if (!run_r[i]) begin
        free_any = 1'b1;
        free_idx = IW'(i);
      end
    end
  end

  assign sid_idx = sid_r[IW-1:0];
  assign kill_ok = (int'(sid_r) < NS) && run_r[sid_idx];
  assign set_bad = (dur_r == '0) || (tag_r == '0);

  // decode of set, kill and unknown requests
  always_comb begin
    res_stat = otb_pkg::ST_ERROR;
    res_slot = '0;
    do_set   = 1'b0;
    do_kill  = 1'b0;
    unique case (req_r)
      otb_pkg::REQ_SET: begin
        if (set_bad) begin
          res_stat = otb_pkg::ST_ERROR;
        end else if (free_any) begin
          res_stat = otb_pkg::ST_OK;
          res_slot = otb_pkg::SLOT_W'(free_idx);
          do_set   = cmd.single;
        end else begin
          res_stat = otb_pkg::ST_FULL;
        end
      end
      otb_pkg::REQ_KILL: begin
        if (kill_ok) begin
          res_stat = otb_pkg::ST_OK;
          do_kill  = cmd.single;
        end
      end
      default: begin
        res_stat = otb_pkg::ST_ERROR;
      end
    endcase
  end

  assign load_out = cmd.single || (cmd.step && hit);

  assign sts.req_tick = (req_r == otb_pkg::REQ_TICK);
  assign sts.hit      = hit;
  assign sts.out_free = out_free;
  assign sts.idx_last = (idx_r == IW'(NS - 1));

  // request capture and walk index
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      req_r <= in_tuser;
      dur_r <= DW'(in_tdata[otb_pkg::IN_DUR_LO +: otb_pkg::DUR_W]);
      tag_r <= in_tdata[otb_pkg::IN_TAG_LO +: otb_pkg::TAG_W];
      sid_r <= in_tdata[otb_pkg::IN_SID_LO +: otb_pkg::SLOT_W];
    end
    if (cmd.load) begin
      idx_r <= '0;
    end else if (cmd.step) begin
      idx_r <= idx_r + IW'(1);
    end
  end

  // running flags
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r <= '0;
    end else if (do_set) begin
      run_r[free_idx] <= 1'b1;
    end else if (do_kill) begin
      run_r[sid_idx] <= 1'b0;
    end else if (cmd.step && hit) begin
      run_r[idx_r] <= 1'b0;
    end
  end

  // counts and tags
  always_ff @(posedge clk) begin
    if (do_set) begin
      rem_r[free_idx]  <= dur_r;
      stag_r[free_idx] <= tag_r;
    end else if (cmd.step && run_r[idx_r]) begin
      rem_r[idx_r] <= rem_r[idx_r] - DW'(1);
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (load_out) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
    if (load_out) begin
      if (cmd.single) begin
        out_stat_r <= res_stat;
        out_slot_r <= res_slot;
        out_tag_r  <= '0;
        out_last_r <= 1'b1;
      end else begin
        out_stat_r <= otb_pkg::ST_EXPIRED;
        out_slot_r <= otb_pkg::SLOT_W'(idx_r);
        out_tag_r  <= stag_r[idx_r];
        out_last_r <= !later_exp;
      end
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {{(otb_pkg::OUT_W - otb_pkg::SLOT_W - otb_pkg::TAG_W){1'b0}},
                       out_tag_r, out_slot_r};
  assign out_tuser  = out_stat_r;
  assign out_tlast  = out_last_r;

  // a waiting result is never overwritten
  `OTB_ASSERT(a_no_overrun, (load_out && out_valid_r) |-> out_tready)
  // an expired slot stops running
  `OTB_ASSERT(a_expiry_frees, (cmd.step && hit) |=> !run_r[$past(idx_r)])
  // no result leaves straight after reset
  `OTB_ASSERT_ALWAYS(a_reset_empty, !rst_n |=> !out_tvalid)

endmodule

// ----- rtl/one_shot_timer_bank.sv -----
// top level of the one-shot timer bank: controller and datapath
//
//   channel  dir  tdata (low bit up)                      tuser        tlast
//   in_      in   duration[31:0] action_tag[39:32]        req_type     -
//                 slot_id[43:40] zero[47:44]
//   out_     out  slot[3:0] expired_tag[11:4] zero[15:12] status       last
//
// set, kill and unknown requests load their result once the output register is free and
// take the next word after that; a tick walks one slot a cycle while no expiring slot stalls
// the walk over the slot table sets how long a tick takes, one slot per cycle
// a stalled output register holds the walk on any slot that expires
// synchronous active-low reset clears running flags and the output register's valid flag
// ready is registered and rises in the cycle after reset is released

module one_shot_timer_bank (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_tvalid,
  output logic                              in_tready,
  // duration, action_tag, slot_id, zero pad
  input  logic [otb_pkg::IN_W-1:0]          in_tdata,
  // req_type
  input  logic [otb_pkg::REQ_W-1:0]         in_tuser,
  output logic                              out_tvalid,
  input  logic                              out_tready,
  // slot, expired_tag, zero pad
  output logic [otb_pkg::OUT_W-1:0]         out_tdata,
  // status
  output logic [otb_pkg::STAT_W-1:0]        out_tuser,
  output logic                              out_tlast
);

  otb_pkg::otb_cmd_t cmd;
  otb_pkg::otb_sts_t sts;

  // sequencing
  otb_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .sts       (sts),
    .cmd       (cmd)
  );

  // slot table and results
  otb_dp u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast),
    .cmd        (cmd),
    .sts        (sts)
  );

endmodule

// ----- verif/otb_checker.sv -----
// checker for the timer bank: predicts each report from accepted words and compares
module otb_checker
  import otb_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  input  logic              in_tready,
  input  logic [IN_W-1:0]   in_tdata,
  input  logic [REQ_W-1:0]  in_tuser,
  input  logic              out_tvalid,
  input  logic              out_tready,
  input  logic [OUT_W-1:0]  out_tdata,
  input  logic [STAT_W-1:0] out_tuser,
  input  logic              out_tlast,
  output int                fail_count,
  output int                pending
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    logic [STAT_W-1:0] status;
    logic [SLOT_W-1:0] slot;
    logic [TAG_W-1:0]  tag;
    logic              last;
  } timer_report_t;

  // shadow copy of the slot table
  logic                     slot_busy [USED_SLOTS];
  logic [DURATION_BITS-1:0] ticks_left [USED_SLOTS];
  logic [TAG_W-1:0]         slot_tag [USED_SLOTS];

  timer_report_t due_reports[$];

  initial begin
    fail_count = 0;
    pending    = 0;
  end

  task automatic queue_report(input logic [STAT_W-1:0] status, input logic [SLOT_W-1:0] slot,
                              input logic [TAG_W-1:0] tag, input logic last);
    timer_report_t r;
    r.status = status;
    r.slot   = slot;
    r.tag    = tag;
    r.last   = last;
    due_reports.push_back(r);
  endtask

  // work out the reports one accepted word causes and update the table
  task automatic advance_bank(input logic [REQ_W-1:0] req, input logic [DUR_W-1:0] dur_in,
                              input logic [TAG_W-1:0] tag, input logic [SLOT_W-1:0] sid);
    logic [DURATION_BITS-1:0] dur;
    int last_hit;
    int free_slot;
    dur       = DURATION_BITS'(dur_in);
    last_hit  = -1;
    free_slot = -1;
    case (req)
      REQ_TICK: begin
        // count down every running slot, then report the ones at zero in slot order
        for (int i = 0; i < USED_SLOTS; i++) begin
          if (slot_busy[i]) begin
            ticks_left[i] = ticks_left[i] - 1'b1;
            if (ticks_left[i] == '0) last_hit = i;
          end
        end
        for (int i = 0; i < USED_SLOTS; i++) begin
          if (slot_busy[i] && ticks_left[i] == '0) begin
            slot_busy[i] = 1'b0;
            queue_report(ST_EXPIRED, SLOT_W'(i), slot_tag[i], i == last_hit);
          end
        end
      end
      REQ_SET: begin
        if (dur == '0 || tag == '0) begin
          queue_report(ST_ERROR, '0, '0, 1'b1);
        end else begin
          for (int i = USED_SLOTS - 1; i >= 0; i--) begin
            if (!slot_busy[i]) free_slot = i;
          end
          if (free_slot < 0) begin
            queue_report(ST_FULL, '0, '0, 1'b1);
          end else begin
            slot_busy[free_slot]  = 1'b1;
            ticks_left[free_slot] = dur;
            slot_tag[free_slot]   = tag;
            queue_report(ST_OK, SLOT_W'(free_slot), '0, 1'b1);
          end
        end
      end
      REQ_KILL: begin
        if (int'(sid) < USED_SLOTS && slot_busy[sid]) begin
          slot_busy[sid] = 1'b0;
          queue_report(ST_OK, '0, '0, 1'b1);
        end else begin
          queue_report(ST_ERROR, '0, '0, 1'b1);
        end
      end
      default: begin
        queue_report(ST_ERROR, '0, '0, 1'b1);
      end
    endcase
  endtask

  task automatic note_failure(input string what);
    fail_count++;
    if (fail_count <= 10) $display("[%0t] otb mismatch: %s", $realtime, what);
  endtask

  // compare one accepted result word with the oldest prediction
  task automatic check_report();
    timer_report_t     want;
    logic [SLOT_W-1:0] got_slot;
    logic [TAG_W-1:0]  got_tag;
    got_slot = out_tdata[SLOT_W-1:0];
    got_tag  = out_tdata[SLOT_W +: TAG_W];
    if (due_reports.size() == 0) begin
      note_failure($sformatf("unexpected word status %0d slot %0d tag %0d last %0d",
                             out_tuser, got_slot, got_tag, out_tlast));
      return;
    end
    want = due_reports.pop_front();
    if (want.status !== out_tuser || want.slot !== got_slot || want.tag !== got_tag ||
        want.last !== out_tlast) begin
      note_failure($sformatf("expected status %0d slot %0d tag %0d last %0d, got %0d %0d %0d %0d",
                             want.status, want.slot, want.tag, want.last,
                             out_tuser, got_slot, got_tag, out_tlast));
    end
  endtask

  // watch both channels
  always @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < USED_SLOTS; i++) slot_busy[i] = 1'b0;
      due_reports.delete();
    end else begin
      if (out_tvalid && out_tready) check_report();
      if (in_tvalid && in_tready) begin
        advance_bank(in_tuser, in_tdata[IN_DUR_LO +: DUR_W], in_tdata[IN_TAG_LO +: TAG_W],
                     in_tdata[IN_SID_LO +: SLOT_W]);
      end
    end
    pending <= due_reports.size();
  end

endmodule

// ----- verif/one_shot_timer_bank_tb.sv -----
// testbench top for the timer bank: clock, reset, word stimulus and verdict
module one_shot_timer_bank_tb;
  import otb_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [REQ_W-1:0] REQ_UNKNOWN = 2'd3;
  localparam int RANDOM_WORDS = 450;

  logic              clk        = 1'b0;
  logic              rst_n      = 1'b0;
  logic              in_tvalid  = 1'b0;
  logic              in_tready;
  logic [IN_W-1:0]   in_tdata   = '0;
  logic [REQ_W-1:0]  in_tuser   = '0;
  logic              out_tvalid;
  logic              out_tready = 1'b0;
  logic [OUT_W-1:0]  out_tdata;
  logic [STAT_W-1:0] out_tuser;
  logic              out_tlast;
  int                fail_count;
  int                pending;

  one_shot_timer_bank dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  otb_checker report_watch (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast),
    .fail_count (fail_count),
    .pending    (pending)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // run limit
  initial begin
    #2_000_000;
    $display("Verification failed");
    $finish;
  end

  // result side: random stalls, one long hold-off and a stretch with no stalls
  initial begin : result_sink
    int cycle_no;
    cycle_no = 0;
    forever begin
      @(posedge clk);
      cycle_no++;
      if (cycle_no >= 600 && cycle_no < 1000) begin
        out_tready <= 1'b0;
      end else if (cycle_no >= 2000 && cycle_no < 3000) begin
        out_tready <= 1'b1;
      end else begin
        out_tready <= ($urandom_range(99) >= 12);
      end
    end
  end

  // offer one request word and hold it until it is taken
  task automatic offer_word(input logic [REQ_W-1:0] req, input logic [DUR_W-1:0] dur,
                            input logic [TAG_W-1:0] tag, input logic [SLOT_W-1:0] sid);
    in_tvalid <= 1'b1;
    in_tuser  <= req;
    in_tdata  <= {{(IN_W - IN_SID_LO - SLOT_W){1'b0}}, sid, tag, dur};
    do @(posedge clk); while (!in_tready);
  endtask

  task automatic source_gap(input bit allow);
    while (allow && $urandom_range(99) < 12) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
  endtask

  // random request word: mostly well-formed sets, ticks and kills, some rejects
  task automatic random_word(input bit allow);
    int               pick;
    int               spread;
    logic [REQ_W-1:0] req;
    logic [DUR_W-1:0] dur;
    logic [TAG_W-1:0] tag;
    logic [SLOT_W-1:0] sid;
    pick   = $urandom_range(99);
    spread = $urandom_range(99);
    dur    = $urandom;
    tag    = TAG_W'($urandom_range(255));
    sid    = SLOT_W'($urandom_range(15));
    if (pick < 40) begin
      req = REQ_TICK;
    end else if (pick < 75) begin
      req = REQ_SET;
      tag = TAG_W'($urandom_range(255, 1));
      if (spread < 70) dur = $urandom_range(8, 1);
      else if (spread < 88) dur = $urandom_range(60, 9);
    end else if (pick < 90) begin
      // busy slots cluster low, so lean kills that way
      req = REQ_KILL;
      if (spread < 50) sid = SLOT_W'($urandom_range(7));
    end else if (pick < 95) begin
      req = REQ_SET;
      if (spread < 50) dur = '0;
      else tag = '0;
    end else begin
      req = REQ_UNKNOWN;
    end
    source_gap(allow);
    offer_word(req, dur, tag, sid);
  endtask

  // stimulus and verdict
  initial begin
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: empty tick, rejects, unknown kind, idle kill, widest set and kill
    offer_word(REQ_TICK, '0, '0, '0);
    offer_word(REQ_SET, '0, 8'd5, '0);
    offer_word(REQ_SET, 32'd3, '0, '0);
    offer_word(REQ_UNKNOWN, '1, '1, '1);
    offer_word(REQ_KILL, '0, '0, 4'd0);
    offer_word(REQ_SET, 32'hFFFF_FFFF, 8'hFF, '0);
    offer_word(REQ_KILL, '1, '0, 4'd0);

    // fill every slot, overflow once, then expire all sixteen on one tick
    for (int i = 0; i < USED_SLOTS; i++) begin
      source_gap(1'b1);
      offer_word(REQ_SET, 32'd1, (i == USED_SLOTS - 1) ? 8'hFF : TAG_W'(i + 1), '0);
    end
    offer_word(REQ_SET, 32'd7, 8'h42, '0);
    offer_word(REQ_TICK, '0, '0, '0);

    for (int n = 0; n < RANDOM_WORDS; n++) random_word(!(n >= 150 && n < 250));
    in_tvalid <= 1'b0;

    // drain outstanding reports, then let any tick walk finish
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (40) @(posedge clk);

    if (fail_count == 0 && pending == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

// ----- one_shot_timer_bank.f -----
+incdir+rtl
rtl/otb_pkg.sv
rtl/otb_ctrl.sv
rtl/otb_dp.sv
rtl/one_shot_timer_bank.sv
verif/otb_checker.sv
verif/one_shot_timer_bank_tb.sv
